FILE: src/mtg_pkg.sv
// shared types, constants and helper functions of the mersenne twister generator
package mtg_pkg;

  localparam int unsigned WORDS = 624;
  localparam int unsigned MID = 397;
  localparam logic [9:0] LAST_IDX = 10'd623;
  localparam logic [9:0] WORDS_V = 10'd624;

  localparam logic [31:0] MATRIX = 32'h9908B0DF;
  localparam logic [31:0] K_LIN = 32'h6C078965;
  localparam logic [31:0] K_ARR1 = 32'h0019660D;
  localparam logic [31:0] K_ARR2 = 32'h5D588B65;
  localparam logic [31:0] ARR_SEED = 32'h012BD6AA;
  localparam logic [31:0] UPPER = 32'h80000000;
  localparam logic [31:0] T_MASK_B = 32'h9D2C5680;
  localparam logic [31:0] T_MASK_C = 32'hEFC60000;
  localparam logic [31:0] ME1_MASK0 = 32'h3CD68000;
  localparam logic [31:0] ME1_MASK1 = 32'h576BAD28;
  localparam logic [31:0] ME1_MASK2 = 32'hD6740000;
  localparam logic [31:0] ME1_MASK3 = 32'h09040000;
  localparam logic [31:0] ME2_MASK0 = 32'hB219BEAB;
  localparam logic [31:0] ME2_MASK1 = 32'h56BDE52A;

  localparam logic [9:0] OFF_MID = 10'd397;
  localparam logic [9:0] OFF_ONE = 10'd1;

  localparam logic [2:0] ME1_LAST = 3'd7;
  localparam logic [2:0] ME2_LAST = 3'd5;

  // request function codes
  localparam logic [1:0] FUNC_SEED = 2'd0;
  localparam logic [1:0] FUNC_KEY = 2'd1;

  // generator variants
  localparam logic [1:0] VAR_CLASSIC = 2'd0;
  localparam logic [1:0] VAR_ME1 = 2'd1;
  localparam logic [1:0] VAR_ME2 = 2'd2;

  // result status codes
  localparam logic [2:0] STS_DRAWN = 3'd0;
  localparam logic [2:0] STS_SEEDED = 3'd1;
  localparam logic [2:0] STS_KEY_STORED = 3'd2;
  localparam logic [2:0] STS_KEY_DROPPED = 3'd3;
  localparam logic [2:0] STS_UNSEEDED = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] seed_word;
    logic        key_last;
  } req_t;

  typedef struct packed {
    logic [31:0] random_value;
    logic [2:0]  status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIN_MUL,
    S_LIN_WR,
    S_ARR_RD,
    S_ARR_WR,
    S_ARR_WRAP,
    S_ARR_TOP,
    S_START,
    S_GEN_A,
    S_GEN_B,
    S_GEN_C,
    S_GEN_W,
    S_CL_RD,
    S_CL_OUT,
    S_ME_A,
    S_ME_B,
    S_ME_C,
    S_ME_W,
    S_ME_TR,
    S_ME_TC,
    S_ME_OUT,
    S_DONE
  } state_t;

  function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] y;
    y = {a[31], b[30:0]};
    return (y >> 1) ^ (y[0] ? MATRIX : 32'h0);
  endfunction

  // (p + off) mod 624 for p, off below 624
  function automatic logic [9:0] wrap_add(input logic [9:0] p, input logic [9:0] off);
    logic [10:0] s;
    s = {1'b0, p} + {1'b0, off};
    if (s >= {1'b0, WORDS_V}) s = s - {1'b0, WORDS_V};
    return s[9:0];
  endfunction

  function automatic logic [31:0] temper_classic(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & T_MASK_B);
    y = y ^ ((y << 15) & T_MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [9:0] me_limit(input logic second, input logic [2:0] ph);
    logic [9:0] l;
    l = 10'd0;
    if (!second) begin
      unique case (ph)
        3'd1: l = 10'd227;
        3'd2: l = 10'd300;
        3'd3: l = 10'd400;
        3'd4: l = 10'd500;
        3'd5: l = 10'd600;
        3'd6: l = 10'd623;
        default: l = 10'd0;
      endcase
    end else begin
      unique case (ph)
        3'd1: l = 10'd227;
        3'd2: l = 10'd473;
        3'd3: l = 10'd588;
        3'd4: l = 10'd623;
        default: l = 10'd0;
      endcase
    end
    return l;
  endfunction

  // tap distances for the me tempering reads
  function automatic logic [9:0] me_tap_off(input logic second, input logic [1:0] tap);
    logic [9:0] o;
    o = 10'd0;
    if (!second) begin
      unique case (tap)
        2'd0: o = 10'd224;
        2'd1: o = 10'd124;
        2'd2: o = 10'd24;
        2'd3: o = 10'd324;
        default: o = 10'd0;
      endcase
    end else begin
      o = (tap == 2'd0) ? 10'd151 : 10'd36;
    end
    return o;
  endfunction

endpackage

FILE: src/mtg_ram.sv
// generic single write, single read ram with registered read data
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mersenne_twister_generator_core.sv
// top level of the mersenne twister generator: sequencer, shared multiplier and state rams
//
// Requests come in on in_valid/in_req and are taken when in_stall is low.
// func 0 seeds from one word, func 1 stores a key word (key_last starts
// array seeding over the stored words), func 2 or 3 draws one word.
// Each request gives exactly one result on out_valid/out_rsp, held until
// out_stall is low. The user writes the variant on cfg_we/cfg_wdata only while
// idle (the block does not enforce this); it is latched at the next seeding.
// The block works on one request at a time. A key word is stored directly;
// a classic draw reads and tempers one word, and once every 624 draws first
// regenerates the state (4 reads/writes per word); me draws twist one word
// and then read the tempering taps (I: 4 taps, II: 2 taps); single-word
// seeding runs the multiplier, then the write, for each word; array seeding
// adds max(624,n) mixing steps for n key words, then 623 more.
// The result sits in an output register, so a stalled result does not
// block the next request from being taken. Reset (rst_n low, synchronous)
// returns to the unseeded state; the state rams need no clearing.
module mersenne_twister_generator_core #(
  parameter int MAX_KEY_WORDS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtg_pkg::req_t       in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output mtg_pkg::rsp_t       out_rsp,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);

  localparam int KIDX_W = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KCNT_W = $clog2(MAX_KEY_WORDS + 1);
  localparam int LOOP_MAX = (MAX_KEY_WORDS > 624) ? MAX_KEY_WORDS : 624;
  localparam int LOOP_W = $clog2(LOOP_MAX + 1);

  mtg_pkg::state_t state_r, state_nxt;

  logic [9:0]        idx_r, idx_nxt;
  logic [LOOP_W-1:0] loop_r, loop_nxt;
  logic [KIDX_W-1:0] j_r, j_nxt;
  logic [31:0]       q_r, q_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [31:0]       a_r, a_nxt;
  logic [31:0]       b_r, b_nxt;
  logic [31:0]       y_r, y_nxt;
  logic [1:0]        tap_r, tap_nxt;
  logic [9:0]        rp_r, rp_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [KCNT_W-1:0] key_count_r, key_count_nxt;
  logic              seeded_r, seeded_nxt;
  logic [1:0]        active_r, active_nxt;
  logic [1:0]        variant_r;
  logic              pass_r, pass_nxt;
  logic              arr_r, arr_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [31:0]       value_r, value_nxt;
  logic              out_valid_r;
  mtg_pkg::rsp_t     out_rsp_r;

  logic        accept;
  logic        out_load;
  logic        key_full;
  logic        second;
  logic        draw_is_me;
  logic [1:0]  last_tap;
  logic [9:0]  p_draw;

  logic        g_we;
  logic [9:0]  g_waddr;
  logic [31:0] g_wdata;
  logic [9:0]  g_raddr;
  logic [31:0] g_rdata;

  logic              k_we;
  logic [KIDX_W-1:0] k_raddr;
  logic [31:0]       k_rdata;

  logic [31:0] mul_a;
  logic [31:0] mul_k;
  logic [31:0] mul_lo;
  logic [31:0] arr_t;
  logic [31:0] twist_t;
  logic [31:0] me_y2;
  logic [31:0] me_y3;
  logic [2:0]  ph_ok;
  logic [2:0]  ph_last;
  logic [9:0]  rp_inc;
  logic        j_wrap;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != mtg_pkg::S_IDLE);
  assign out_load = (state_r == mtg_pkg::S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

  assign key_full = (key_count_r == KCNT_W'(MAX_KEY_WORDS));
  assign second = (active_r == mtg_pkg::VAR_ME2);
  assign draw_is_me = (active_r == mtg_pkg::VAR_ME1) || (active_r == mtg_pkg::VAR_ME2);
  assign last_tap = second ? 2'd1 : 2'd3;
  assign p_draw = (rp_r >= mtg_pkg::WORDS_V) ? (rp_r - mtg_pkg::WORDS_V) : rp_r;
  assign j_wrap = (KCNT_W'(j_r) + KCNT_W'(1)) == key_count_r;

  // shared multiplier for all seeding recurrences, low word only
  assign mul_a = q_r ^ (q_r >> 30);
  assign mul_k = (state_r == mtg_pkg::S_LIN_MUL) ? mtg_pkg::K_LIN :
                 (pass_r ? mtg_pkg::K_ARR2 : mtg_pkg::K_ARR1);
  assign mul_lo = mul_a * mul_k;

  assign arr_t = pass_r ? ((g_rdata ^ prod_r) - {22'h0, idx_r})
                        : ((g_rdata ^ prod_r) + k_rdata + 32'(j_r));
  assign twist_t = g_rdata ^ mtg_pkg::twist(a_r, b_r);

  assign ph_last = second ? mtg_pkg::ME2_LAST : mtg_pkg::ME1_LAST;
  assign ph_ok = (phase_r < 3'd1 || phase_r > ph_last) ? 3'd1 : phase_r;
  assign rp_inc = idx_r + 10'd1;

  always_comb begin
    if (second) begin
      me_y2 = y_r ^ (y_r << 8);
      me_y3 = me_y2 ^ (me_y2 << 14);
    end else begin
      me_y2 = y_r ^ (y_r >> 11);
      me_y3 = me_y2 ^ (me_y2 << 7);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtg_pkg::S_IDLE: begin
        if (accept) begin
          if (in_req.func == mtg_pkg::FUNC_SEED) begin
            state_nxt = mtg_pkg::S_LIN_MUL;
          end else if (in_req.func == mtg_pkg::FUNC_KEY) begin
            state_nxt = in_req.key_last ? mtg_pkg::S_LIN_MUL : mtg_pkg::S_DONE;
          end else if (!seeded_r) begin
            state_nxt = mtg_pkg::S_DONE;
          end else if (draw_is_me) begin
            state_nxt = mtg_pkg::S_ME_A;
          end else if (rp_r >= mtg_pkg::WORDS_V) begin
            state_nxt = mtg_pkg::S_GEN_A;
          end else begin
            state_nxt = mtg_pkg::S_CL_RD;
          end
        end
      end
      mtg_pkg::S_LIN_MUL: state_nxt = mtg_pkg::S_LIN_WR;
      mtg_pkg::S_LIN_WR: begin
        if (idx_r == mtg_pkg::LAST_IDX) begin
          state_nxt = arr_r ? mtg_pkg::S_ARR_RD : mtg_pkg::S_START;
        end else begin
          state_nxt = mtg_pkg::S_LIN_MUL;
        end
      end
      mtg_pkg::S_ARR_RD: state_nxt = mtg_pkg::S_ARR_WR;
      mtg_pkg::S_ARR_WR: begin
        if (idx_r == mtg_pkg::LAST_IDX) begin
          state_nxt = mtg_pkg::S_ARR_WRAP;
        end else if (pass_r && loop_r == LOOP_W'(1)) begin
          state_nxt = mtg_pkg::S_ARR_TOP;
        end else begin
          state_nxt = mtg_pkg::S_ARR_RD;
        end
      end
      mtg_pkg::S_ARR_WRAP: begin
        state_nxt = (pass_r && loop_r == '0) ? mtg_pkg::S_ARR_TOP : mtg_pkg::S_ARR_RD;
      end
      mtg_pkg::S_ARR_TOP: state_nxt = mtg_pkg::S_START;
      mtg_pkg::S_START:   state_nxt = mtg_pkg::S_DONE;
      mtg_pkg::S_GEN_A:   state_nxt = mtg_pkg::S_GEN_B;
      mtg_pkg::S_GEN_B:   state_nxt = mtg_pkg::S_GEN_C;
      mtg_pkg::S_GEN_C:   state_nxt = mtg_pkg::S_GEN_W;
      mtg_pkg::S_GEN_W: begin
        state_nxt = (idx_r == mtg_pkg::LAST_IDX) ? mtg_pkg::S_CL_RD : mtg_pkg::S_GEN_A;
      end
      mtg_pkg::S_CL_RD:  state_nxt = mtg_pkg::S_CL_OUT;
      mtg_pkg::S_CL_OUT: state_nxt = mtg_pkg::S_DONE;
      mtg_pkg::S_ME_A:   state_nxt = mtg_pkg::S_ME_B;
      mtg_pkg::S_ME_B:   state_nxt = mtg_pkg::S_ME_C;
      mtg_pkg::S_ME_C:   state_nxt = mtg_pkg::S_ME_W;
      mtg_pkg::S_ME_W:   state_nxt = mtg_pkg::S_ME_TR;
      mtg_pkg::S_ME_TR:  state_nxt = mtg_pkg::S_ME_TC;
      mtg_pkg::S_ME_TC: begin
        state_nxt = (tap_r == last_tap) ? mtg_pkg::S_ME_OUT : mtg_pkg::S_ME_TR;
      end
      mtg_pkg::S_ME_OUT: state_nxt = mtg_pkg::S_DONE;
      mtg_pkg::S_DONE: begin
        if (out_load) state_nxt = mtg_pkg::S_IDLE;
      end
      default: state_nxt = mtg_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control per state
  always_comb begin
    idx_nxt = idx_r;
    loop_nxt = loop_r;
    j_nxt = j_r;
    q_nxt = q_r;
    prod_nxt = prod_r;
    a_nxt = a_r;
    b_nxt = b_r;
    y_nxt = y_r;
    tap_nxt = tap_r;
    rp_nxt = rp_r;
    phase_nxt = phase_r;
    key_count_nxt = key_count_r;
    seeded_nxt = seeded_r;
    active_nxt = active_r;
    pass_nxt = pass_r;
    arr_nxt = arr_r;
    status_nxt = status_r;
    value_nxt = value_r;
    g_we = 1'b0;
    g_waddr = idx_r;
    g_wdata = q_r;
    g_raddr = idx_r;
    k_we = 1'b0;
    k_raddr = j_r;
    unique case (state_r)
      mtg_pkg::S_IDLE: begin
        if (accept) begin
          value_nxt = 32'h0;
          idx_nxt = 10'd1;
          arr_nxt = 1'b0;
          if (in_req.func == mtg_pkg::FUNC_SEED) begin
            q_nxt = in_req.seed_word;
            g_we = 1'b1;
            g_waddr = 10'd0;
            g_wdata = in_req.seed_word;
            key_count_nxt = '0;
            status_nxt = mtg_pkg::STS_SEEDED;
          end else if (in_req.func == mtg_pkg::FUNC_KEY) begin
            if (!key_full) begin
              k_we = 1'b1;
              key_count_nxt = key_count_r + KCNT_W'(1);
              status_nxt = in_req.key_last ? mtg_pkg::STS_SEEDED : mtg_pkg::STS_KEY_STORED;
            end else begin
              status_nxt = mtg_pkg::STS_KEY_DROPPED;
            end
            if (in_req.key_last) begin
              arr_nxt = 1'b1;
              q_nxt = mtg_pkg::ARR_SEED;
              g_we = 1'b1;
              g_waddr = 10'd0;
              g_wdata = mtg_pkg::ARR_SEED;
            end
          end else if (!seeded_r) begin
            status_nxt = mtg_pkg::STS_UNSEEDED;
          end else begin
            status_nxt = mtg_pkg::STS_DRAWN;
            idx_nxt = draw_is_me ? p_draw : 10'd0;
          end
        end
      end
      mtg_pkg::S_LIN_MUL: prod_nxt = mul_lo;
      mtg_pkg::S_LIN_WR: begin
        g_we = 1'b1;
        g_wdata = prod_r + {22'h0, idx_r};
        q_nxt = g_wdata;
        if (idx_r == mtg_pkg::LAST_IDX) begin
          // array mixing starts from word zero
          q_nxt = mtg_pkg::ARR_SEED;
          idx_nxt = 10'd1;
          j_nxt = '0;
          pass_nxt = 1'b0;
          loop_nxt = (LOOP_W'(key_count_r) > LOOP_W'(mtg_pkg::WORDS)) ?
                     LOOP_W'(key_count_r) : LOOP_W'(mtg_pkg::WORDS);
        end else begin
          idx_nxt = idx_r + 10'd1;
        end
      end
      mtg_pkg::S_ARR_RD: prod_nxt = mul_lo;
      mtg_pkg::S_ARR_WR: begin
        g_we = 1'b1;
        g_wdata = arr_t;
        q_nxt = arr_t;
        j_nxt = j_wrap ? '0 : j_r + KIDX_W'(1);
        if (!pass_r && loop_r == LOOP_W'(1)) begin
          pass_nxt = 1'b1;
          loop_nxt = LOOP_W'(mtg_pkg::WORDS - 1);
        end else begin
          loop_nxt = loop_r - LOOP_W'(1);
        end
        idx_nxt = (idx_r == mtg_pkg::LAST_IDX) ? 10'd1 : idx_r + 10'd1;
      end
      mtg_pkg::S_ARR_WRAP: begin
        // word zero follows the last word written
        g_we = 1'b1;
        g_waddr = 10'd0;
        g_wdata = q_r;
      end
      mtg_pkg::S_ARR_TOP: begin
        g_we = 1'b1;
        g_waddr = 10'd0;
        g_wdata = mtg_pkg::UPPER;
      end
      mtg_pkg::S_START: begin
        active_nxt = (variant_r == mtg_pkg::VAR_ME1 || variant_r == mtg_pkg::VAR_ME2) ?
                     variant_r : mtg_pkg::VAR_CLASSIC;
        if (active_nxt == mtg_pkg::VAR_CLASSIC) begin
          rp_nxt = mtg_pkg::WORDS_V;
          phase_nxt = 3'd0;
        end else begin
          rp_nxt = 10'd0;
          phase_nxt = 3'd1;
        end
        key_count_nxt = '0;
        seeded_nxt = 1'b1;
      end
      mtg_pkg::S_GEN_A: g_raddr = idx_r;
      mtg_pkg::S_GEN_B: begin
        a_nxt = g_rdata;
        g_raddr = mtg_pkg::wrap_add(idx_r, mtg_pkg::OFF_ONE);
      end
      mtg_pkg::S_GEN_C: begin
        b_nxt = g_rdata;
        g_raddr = mtg_pkg::wrap_add(idx_r, mtg_pkg::OFF_MID);
      end
      mtg_pkg::S_GEN_W: begin
        g_we = 1'b1;
        g_wdata = twist_t;
        if (idx_r == mtg_pkg::LAST_IDX) begin
          rp_nxt = 10'd0;
        end else begin
          idx_nxt = idx_r + 10'd1;
        end
      end
      mtg_pkg::S_CL_RD: g_raddr = rp_r;
      mtg_pkg::S_CL_OUT: begin
        value_nxt = mtg_pkg::temper_classic(g_rdata);
        rp_nxt = rp_r + 10'd1;
      end
      mtg_pkg::S_ME_A: g_raddr = idx_r;
      mtg_pkg::S_ME_B: begin
        a_nxt = g_rdata;
        g_raddr = mtg_pkg::wrap_add(idx_r, mtg_pkg::OFF_ONE);
      end
      mtg_pkg::S_ME_C: begin
        b_nxt = g_rdata;
        g_raddr = mtg_pkg::wrap_add(idx_r, mtg_pkg::OFF_MID);
      end
      mtg_pkg::S_ME_W: begin
        g_we = 1'b1;
        g_wdata = twist_t;
        y_nxt = twist_t;
        tap_nxt = 2'd0;
      end
      mtg_pkg::S_ME_TR: g_raddr = mtg_pkg::wrap_add(idx_r, mtg_pkg::me_tap_off(second, tap_r));
      mtg_pkg::S_ME_TC: begin
        tap_nxt = tap_r + 2'd1;
        if (tap_r == last_tap) begin
          a_nxt = g_rdata;
        end else if (second) begin
          y_nxt = y_r ^ (g_rdata & mtg_pkg::ME2_MASK0);
        end else begin
          unique case (tap_r)
            2'd0: y_nxt = y_r ^ ((g_rdata << 14) & mtg_pkg::ME1_MASK0);
            2'd1: y_nxt = y_r ^ ((g_rdata << 3) & mtg_pkg::ME1_MASK1);
            2'd2: y_nxt = y_r ^ ((g_rdata << 18) & mtg_pkg::ME1_MASK2);
            default: y_nxt = y_r;
          endcase
        end
      end
      mtg_pkg::S_ME_OUT: begin
        value_nxt = me_y3 ^ (a_r & (second ? mtg_pkg::ME2_MASK1 : mtg_pkg::ME1_MASK3));
        if (ph_ok == ph_last) begin
          rp_nxt = 10'd0;
          phase_nxt = 3'd1;
        end else begin
          rp_nxt = rp_inc;
          phase_nxt = (rp_inc == mtg_pkg::me_limit(second, ph_ok)) ? ph_ok + 3'd1 : ph_ok;
        end
      end
      mtg_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtg_pkg::S_IDLE;
      rp_r <= 10'd0;
      phase_r <= 3'd0;
      key_count_r <= '0;
      seeded_r <= 1'b0;
      active_r <= mtg_pkg::VAR_CLASSIC;
      variant_r <= mtg_pkg::VAR_CLASSIC;
      out_valid_r <= 1'b0;
      pass_r <= 1'b0;
      arr_r <= 1'b0;
      loop_r <= '0;
      j_r <= '0;
      idx_r <= 10'd0;
      tap_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      rp_r <= rp_nxt;
      phase_r <= phase_nxt;
      key_count_r <= key_count_nxt;
      seeded_r <= seeded_nxt;
      active_r <= active_nxt;
      pass_r <= pass_nxt;
      arr_r <= arr_nxt;
      loop_r <= loop_nxt;
      j_r <= j_nxt;
      idx_r <= idx_nxt;
      tap_r <= tap_nxt;
      if (cfg_we) variant_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    prod_r <= prod_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    y_r <= y_nxt;
    status_r <= status_nxt;
    value_r <= value_nxt;
    if (out_load) begin
      out_rsp_r.random_value <= value_r;
      out_rsp_r.status <= status_r;
    end
  end

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(mtg_pkg::WORDS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  mtg_ram #(
    .WIDTH(32),
    .DEPTH(MAX_KEY_WORDS)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_count_r[KIDX_W-1:0]),
    .wdata (in_req.seed_word),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r <= mtg_pkg::WORDS_V)
    else $error("read position beyond state size");

  a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= KCNT_W'(MAX_KEY_WORDS))
    else $error("key count beyond key store");

  a_me_only_me: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mtg_pkg::S_ME_A |-> draw_is_me && seeded_r)
    else $error("me draw without me variant");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != mtg_pkg::S_IDLE)
    else $error("request accepted without work");

  a_me_rp: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r && draw_is_me |-> rp_r < mtg_pkg::WORDS_V)
    else $error("me read position out of range");

endmodule

FILE: dv/mersenne_twister_generator_core_tb.sv
// testbench for the mersenne twister generator core: directed and random requests
`timescale 1ns / 100ps

module mersenne_twister_generator_core_tb;

  localparam int KEY_DEPTH = 64;
  localparam logic [1:0] FUNC_DRAW = 2'd2;
  localparam logic [1:0] FUNC_DRAW_ALT = 2'd3;
  localparam logic [1:0] VAR_ALIAS = 2'd3;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mtg_pkg::req_t in_req;
  logic out_valid;
  logic out_stall;
  mtg_pkg::rsp_t out_rsp;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  // golden generator state
  logic [31:0] gen_words [mtg_pkg::WORDS];
  logic [31:0] key_store [KEY_DEPTH];
  int unsigned rd_pos;
  int unsigned phase;
  int unsigned key_cnt;
  bit seeded;
  logic [1:0] active_var;
  logic [1:0] var_reg;

  mtg_pkg::rsp_t expected_rsp [$];
  int errors;
  longint cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_recv;

  mersenne_twister_generator_core #(.MAX_KEY_WORDS(KEY_DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] y;
    y = {a[31], b[30:0]};
    return (y >> 1) ^ (y[0] ? 32'h9908B0DF : 32'h0);
  endfunction

  function automatic logic [31:0] word_at(input int unsigned p, input int unsigned off);
    return gen_words[(p + off) % mtg_pkg::WORDS];
  endfunction

  function automatic void linear_fill(input logic [31:0] s);
    logic [31:0] q;
    gen_words[0] = s;
    for (int i = 1; i < mtg_pkg::WORDS; i++) begin
      q = gen_words[i-1];
      gen_words[i] = 32'h6C078965 * (q ^ (q >> 30)) + i;
    end
  endfunction

  function automatic void array_fill();
    int unsigned i, j, n;
    logic [31:0] q;
    i = 1;
    j = 0;
    linear_fill(32'h012BD6AA);
    n = (mtg_pkg::WORDS > key_cnt) ? mtg_pkg::WORDS : key_cnt;
    for (int k = 0; k < n; k++) begin
      q = gen_words[i-1];
      gen_words[i] = (gen_words[i] ^ ((q ^ (q >> 30)) * 32'h0019660D))
                     + key_store[j % KEY_DEPTH] + j;
      i++;
      if (i >= mtg_pkg::WORDS) begin
        gen_words[0] = gen_words[mtg_pkg::WORDS-1];
        i = 1;
      end
      j++;
      if (j >= key_cnt) j = 0;
    end
    for (int k = 0; k < mtg_pkg::WORDS - 1; k++) begin
      q = gen_words[i-1];
      gen_words[i] = (gen_words[i] ^ ((q ^ (q >> 30)) * 32'h5D588B65)) - i;
      i++;
      if (i >= mtg_pkg::WORDS) begin
        gen_words[0] = gen_words[mtg_pkg::WORDS-1];
        i = 1;
      end
    end
    gen_words[0] = 32'h80000000;
  endfunction

  function automatic void start_gen();
    active_var = (var_reg == mtg_pkg::VAR_ME1 || var_reg == mtg_pkg::VAR_ME2) ?
                 var_reg : mtg_pkg::VAR_CLASSIC;
    if (active_var == mtg_pkg::VAR_CLASSIC) begin
      rd_pos = mtg_pkg::WORDS;
      phase = 0;
    end else begin
      rd_pos = 0;
      phase = 1;
    end
    key_cnt = 0;
    seeded = 1'b1;
  endfunction

  function automatic logic [31:0] classic_draw();
    logic [31:0] y;
    if (rd_pos >= mtg_pkg::WORDS) begin
      for (int i = 0; i < mtg_pkg::WORDS; i++)
        gen_words[i] = gen_words[(i + mtg_pkg::MID) % mtg_pkg::WORDS]
                       ^ mix(gen_words[i], gen_words[(i + 1) % mtg_pkg::WORDS]);
      rd_pos = 0;
    end
    y = gen_words[rd_pos];
    rd_pos++;
    y ^= y >> 11;
    y ^= (y << 7) & 32'h9D2C5680;
    y ^= (y << 15) & 32'hEFC60000;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic int unsigned phase_limit(input bit second, input int unsigned ph);
    int unsigned l1 [8] = '{0, 227, 300, 400, 500, 600, 623, 0};
    int unsigned l2 [6] = '{0, 227, 473, 588, 623, 0};
    return second ? l2[ph] : l1[ph];
  endfunction

  function automatic logic [31:0] me_draw(input bit second);
    int unsigned p, last_ph;
    logic [31:0] y;
    p = rd_pos % mtg_pkg::WORDS;
    gen_words[p] = word_at(p, mtg_pkg::MID) ^ mix(gen_words[p], word_at(p, 1));
    if (!second) begin
      y = gen_words[p] ^ ((word_at(p, 224) << 14) & 32'h3CD68000)
          ^ ((word_at(p, 124) << 3) & 32'h576BAD28)
          ^ ((word_at(p, 24) << 18) & 32'hD6740000);
      y ^= y >> 11;
      y ^= y << 7;
      y ^= word_at(p, 324) & 32'h09040000;
      last_ph = 7;
    end else begin
      y = gen_words[p] ^ (word_at(p, 151) & 32'hB219BEAB);
      y ^= y << 8;
      y ^= y << 14;
      y ^= word_at(p, 36) & 32'h56BDE52A;
      last_ph = 5;
    end
    rd_pos = p;
    if (phase < 1 || phase > last_ph) phase = 1;
    rd_pos++;
    if (phase == last_ph) begin
      rd_pos = 0;
      phase = 1;
    end else if (rd_pos == phase_limit(second, phase)) begin
      phase++;
    end
    return y;
  endfunction

  function automatic mtg_pkg::rsp_t predict_rsp(input mtg_pkg::req_t r);
    mtg_pkg::rsp_t o;
    o.random_value = '0;
    if (r.func == mtg_pkg::FUNC_SEED) begin
      linear_fill(r.seed_word);
      start_gen();
      o.status = mtg_pkg::STS_SEEDED;
    end else if (r.func == mtg_pkg::FUNC_KEY) begin
      if (key_cnt < KEY_DEPTH) begin
        key_store[key_cnt] = r.seed_word;
        key_cnt++;
        o.status = mtg_pkg::STS_KEY_STORED;
      end else begin
        o.status = mtg_pkg::STS_KEY_DROPPED;
      end
      if (r.key_last) begin
        array_fill();
        start_gen();
        if (o.status == mtg_pkg::STS_KEY_STORED) o.status = mtg_pkg::STS_SEEDED;
      end
    end else if (!seeded) begin
      o.status = mtg_pkg::STS_UNSEEDED;
    end else begin
      if (active_var == mtg_pkg::VAR_ME1) o.random_value = me_draw(1'b0);
      else if (active_var == mtg_pkg::VAR_ME2) o.random_value = me_draw(1'b1);
      else o.random_value = classic_draw();
      o.status = mtg_pkg::STS_DRAWN;
    end
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_rsp);
      end else begin
        if (out_rsp.random_value !== expected_rsp[0].random_value ||
            out_rsp.status !== expected_rsp[0].status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     expected_rsp[0].random_value, expected_rsp[0].status,
                     out_rsp.random_value, out_rsp.status);
        end
        void'(expected_rsp.pop_front());
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mersenne_twister_generator_core_tb failed");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] f, input logic [31:0] w, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_req.func <= f;
    in_req.seed_word <= w;
    in_req.key_last <= l;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rsp.push_back(predict_rsp(in_req));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_variant(input logic [1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    var_reg = v;
  endtask

  task automatic set_idling(input int s, input int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  task automatic test_unseeded();
    send_req(FUNC_DRAW, 32'hFFFFFFFF, 1'b1);
    send_req(FUNC_DRAW_ALT, 32'h0, 1'b0);
  endtask

  task automatic test_variants_directed();
    logic [1:0] vars [4] = '{mtg_pkg::VAR_CLASSIC, mtg_pkg::VAR_ME1, mtg_pkg::VAR_ME2,
                             VAR_ALIAS};
    foreach (vars[v]) begin
      write_variant(vars[v]);
      send_req(mtg_pkg::FUNC_SEED, (v == 0) ? 32'h0 : 32'hFFFFFFFF, 1'b0);
      send_req(FUNC_DRAW, 32'h0, 1'b0);
      send_req(FUNC_DRAW_ALT, 32'hFFFFFFFF, 1'b1);
    end
  endtask

  task automatic test_key_overflow();
    write_variant(mtg_pkg::VAR_ME1);
    send_req(mtg_pkg::FUNC_KEY, 32'h00000123, 1'b1);
    send_req(FUNC_DRAW, 32'h0, 1'b0);
    for (int i = 0; i < KEY_DEPTH; i++) send_req(mtg_pkg::FUNC_KEY, $urandom, 1'b0);
    send_req(mtg_pkg::FUNC_KEY, 32'hFFFFFFFF, 1'b0);
    send_req(mtg_pkg::FUNC_KEY, 32'h0, 1'b1);
    send_req(FUNC_DRAW, 32'h0, 1'b0);
  endtask

  task automatic test_long_run(input logic [1:0] v, input int n);
    write_variant(v);
    send_req(mtg_pkg::FUNC_SEED, $urandom, 1'b0);
    for (int i = 0; i < n; i++) send_req(FUNC_DRAW, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3) send_req(mtg_pkg::FUNC_SEED, $urandom, 1'($urandom_range(1)));
      else if (k < 5) begin
        for (int j = $urandom_range(1, 6); j > 0; j--)
          send_req(mtg_pkg::FUNC_KEY, $urandom, 1'b0);
        send_req(mtg_pkg::FUNC_KEY, $urandom, 1'b1);
      end else if (k < 7) send_req(mtg_pkg::FUNC_KEY, $urandom, 1'b0);
      else send_req($urandom_range(1) ? FUNC_DRAW : FUNC_DRAW_ALT, $urandom,
                    1'($urandom_range(1)));
    end
  endtask

  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_req(FUNC_DRAW, $urandom, 1'b0);
    join
    drain();
    for (int i = 0; i < 8; i++) send_req(FUNC_DRAW, $urandom, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_recv = 1'b0;
    errors = 0;
    cycles = 0;
    rd_pos = 0;
    phase = 0;
    key_cnt = 0;
    seeded = 1'b0;
    active_var = mtg_pkg::VAR_CLASSIC;
    var_reg = mtg_pkg::VAR_CLASSIC;
    foreach (gen_words[i]) gen_words[i] = '0;
    foreach (key_store[i]) key_store[i] = '0;
    set_idling(0, 0);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unseeded();
    test_variants_directed();
    test_key_overflow();
    test_long_run(mtg_pkg::VAR_CLASSIC, 650);
    set_idling(53, 0);
    test_long_run(mtg_pkg::VAR_ME1, 100);
    set_idling(0, 53);
    test_long_run(mtg_pkg::VAR_ME2, 100);
    set_idling(25, 25);
    test_random(100);
    set_idling(0, 0);
    test_backpressure();
    write_variant(mtg_pkg::VAR_ME2);
    set_idling(53, 53);
    test_random(60);

    drain();
    if (errors == 0) $display("mersenne_twister_generator_core_tb passed");
    else $display("mersenne_twister_generator_core_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/mtg_pkg.sv
src/mtg_ram.sv
src/mersenne_twister_generator_core.sv
dv/mersenne_twister_generator_core_tb.sv
